// ===== rtl/mcs_pkg.sv =====
`timescale 1ns / 1ps
// Package for the marching-squares cell block: request and segment structs,
// pipeline depths, edge modes and the case-to-edge-pair table. No dependencies.
package mcs_pkg;

    localparam int DIV_BITS = 31;
    localparam int EDGE_LAT = DIV_BITS + 3;
    localparam int SEG_LAT  = 4;

    typedef struct packed {
        logic [31:0]        corner_ll;
        logic [31:0]        corner_lr;
        logic [31:0]        corner_ul;
        logic [31:0]        corner_ur;
        logic [31:0]        threshold;
        logic [4:0]         band_index;
        logic signed [31:0] cell_x;
        logic signed [31:0] cell_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [4:0]         segment_band;
        logic               last_segment;
    } t_out;

    typedef enum logic [1:0] {
        EM_DIV,
        EM_ZERO,
        EM_HALF,
        EM_FULL
    } t_emode;

    typedef struct packed {
        logic       two;
        logic [1:0] a0;
        logic [1:0] b0;
        logic [1:0] a1;
        logic [1:0] b1;
    } t_pairs;

    typedef struct packed {
        logic [30:0]        ax;
        logic [30:0]        ay;
        logic [30:0]        bx;
        logic [30:0]        by;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } t_seg_in;

    typedef struct packed {
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] ex;
        logic signed [31:0] ey;
    } t_coords;

    typedef struct packed {
        logic    keep;
        t_coords co;
    } t_seg_out;

    localparam logic [1:0] E_BOT = 2'd0;
    localparam logic [1:0] E_RGT = 2'd1;
    localparam logic [1:0] E_TOP = 2'd2;
    localparam logic [1:0] E_LFT = 2'd3;

    function automatic t_pairs pairs_of(input logic [3:0] c, input logic above);
        t_pairs p;
        logic   first;
        p     = '{two: 1'b0, a0: E_LFT, b0: E_BOT, a1: E_LFT, b1: E_BOT};
        first = (c == 4'd5) ? above : !above;
        case (c)
            4'd1, 4'd14: begin p.a0 = E_LFT; p.b0 = E_BOT; end
            4'd2, 4'd13: begin p.a0 = E_BOT; p.b0 = E_RGT; end
            4'd3, 4'd12: begin p.a0 = E_LFT; p.b0 = E_RGT; end
            4'd4, 4'd11: begin p.a0 = E_RGT; p.b0 = E_TOP; end
            4'd6, 4'd9: begin p.a0 = E_BOT; p.b0 = E_TOP; end
            4'd7: begin p.a0 = E_LFT; p.b0 = E_TOP; end
            4'd8: begin p.a0 = E_TOP; p.b0 = E_LFT; end
            4'd5, 4'd10: begin
                p.two = 1'b1;
                if (first) begin
                    p.a0 = E_BOT; p.b0 = E_RGT; p.a1 = E_TOP; p.b1 = E_LFT;
                end else begin
                    p.a0 = E_LFT; p.b0 = E_BOT; p.a1 = E_RGT; p.b1 = E_TOP;
                end
            end
            default: p.two = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [31:0] sat_add(input logic signed [31:0] base,
                                            input logic [30:0] off);
        logic [32:0] s;
        s = {base[31], base} + {2'b00, off};
        if (!s[32] && s[31]) return 32'h7FFF_FFFF;
        return s[31:0];
    endfunction

endpackage

// ===== rtl/mcs_edge.sv =====
`timescale 1ns / 1ps
// Crossing offset along one cell edge: mode decode, step multiply and a
// one-bit-per-stage restoring divider. Depends on mcs_pkg.
module mcs_edge import mcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_va,
    input  logic [31:0] i_vb,
    input  logic [31:0] i_lvl,
    input  logic [30:0] i_step,
    output logic [30:0] o_off
);

    logic signed [32:0] den;
    logic signed [32:0] num;
    logic [31:0]        an;
    logic [31:0]        ad;
    t_emode             mode;

    t_emode      r1_mode;
    logic [31:0] r1_an;
    logic [31:0] r1_ad;
    t_emode      r2_mode;
    logic [62:0] r2_prod;
    logic [31:0] r2_ad;

    logic [31:0] r_rem  [DIV_BITS];
    logic [30:0] r_low  [DIV_BITS];
    logic [30:0] r_q    [DIV_BITS];
    logic [31:0] r_ad   [DIV_BITS];
    t_emode      r_mode [DIV_BITS];

    logic [31:0] n_rem [DIV_BITS];
    logic [30:0] n_low [DIV_BITS];
    logic [30:0] n_q   [DIV_BITS];
    logic [31:0] n_ad  [DIV_BITS];
    t_emode      n_mode[DIV_BITS];

    logic [30:0] r_off;

    assign den = $signed({1'b0, i_vb}) - $signed({1'b0, i_va});
    assign num = $signed({1'b0, i_lvl}) - $signed({1'b0, i_va});
    assign an  = num[32] ? 32'(-num) : num[31:0];
    assign ad  = den[32] ? 32'(-den) : den[31:0];

    always_comb begin
        if (den == '0) begin
            mode = EM_HALF;
        end else if (((num[32] || num == '0) && !den[32])
                  || (!num[32] && den[32])) begin
            mode = EM_ZERO;
        end else if (an >= ad) begin
            mode = EM_FULL;
        end else begin
            mode = EM_DIV;
        end
    end

    always_comb begin
        logic [31:0] s_rem;
        logic [30:0] s_low;
        logic [30:0] s_q;
        logic [32:0] trial;
        for (int k = 0; k < DIV_BITS; k++) begin
            if (k == 0) begin
                s_rem     = r2_prod[62:31];
                s_low     = r2_prod[30:0];
                s_q       = '0;
                n_ad[k]   = r2_ad;
                n_mode[k] = r2_mode;
            end else begin
                s_rem     = r_rem[k-1];
                s_low     = r_low[k-1];
                s_q       = r_q[k-1];
                n_ad[k]   = r_ad[k-1];
                n_mode[k] = r_mode[k-1];
            end
            trial    = {s_rem, s_low[30]};
            n_low[k] = {s_low[29:0], 1'b0};
            if (trial >= {1'b0, n_ad[k]}) begin
                n_rem[k] = 32'(trial - {1'b0, n_ad[k]});
                n_q[k]   = {s_q[29:0], 1'b1};
            end else begin
                n_rem[k] = trial[31:0];
                n_q[k]   = {s_q[29:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_mode <= mode;
            r1_an   <= an;
            r1_ad   <= ad;
            r2_mode <= r1_mode;
            r2_prod <= r1_an * i_step;
            r2_ad   <= r1_ad;
            for (int k = 0; k < DIV_BITS; k++) begin
                r_rem[k]  <= n_rem[k];
                r_low[k]  <= n_low[k];
                r_q[k]    <= n_q[k];
                r_ad[k]   <= n_ad[k];
                r_mode[k] <= n_mode[k];
            end
            case (r_mode[DIV_BITS-1])
                EM_ZERO: r_off <= '0;
                EM_HALF: r_off <= i_step >> 1;
                EM_FULL: r_off <= i_step;
                default: r_off <= r_q[DIV_BITS-1];
            endcase
        end
    end

    assign o_off = r_off;

endmodule

// ===== rtl/mcs_seg.sv =====
`timescale 1ns / 1ps
// One segment: saturated endpoints and the short-segment length test
// over four stages. Depends on mcs_pkg.
module mcs_seg import mcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  t_seg_in     i_seg,
    input  logic [63:0] i_lim,
    output t_seg_out    o_seg
);

    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [63:0] sq_x;
    logic signed [63:0] sq_y;
    logic [72:0]        scaled;

    logic signed [31:0] r_dx;
    logic signed [31:0] r_dy;
    t_coords            r_co_a;
    logic [61:0]        r_sqx;
    logic [61:0]        r_sqy;
    t_coords            r_co_b;
    logic [62:0]        r_d2;
    t_coords            r_co_c;
    t_seg_out           r_out;

    assign dx   = $signed({1'b0, i_seg.ax}) - $signed({1'b0, i_seg.bx});
    assign dy   = $signed({1'b0, i_seg.ay}) - $signed({1'b0, i_seg.by});
    assign sq_x = r_dx * r_dx;
    assign sq_y = r_dy * r_dy;
    assign scaled = (73'(r_d2) << 9) + (73'(r_d2) << 6) + (73'(r_d2) << 5)
                  + (73'(r_d2) << 4) + 73'(r_d2);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx      <= dx;
            r_dy      <= dy;
            r_co_a.sx <= sat_add(i_seg.cx, i_seg.ax);
            r_co_a.sy <= sat_add(i_seg.cy, i_seg.ay);
            r_co_a.ex <= sat_add(i_seg.cx, i_seg.bx);
            r_co_a.ey <= sat_add(i_seg.cy, i_seg.by);
            r_sqx     <= sq_x[61:0];
            r_sqy     <= sq_y[61:0];
            r_co_b    <= r_co_a;
            r_d2      <= {1'b0, r_sqx} + {1'b0, r_sqy};
            r_co_c    <= r_co_b;
            r_out.keep <= !(scaled < {9'b0, i_lim});
            r_out.co   <= r_co_c;
        end
    end

    assign o_seg = r_out;

endmodule

// ===== rtl/marching_squares_cell.sv =====
`timescale 1ns / 1ps
// Pipeline: input stage, 34-stage edge unit, 4-stage segment test, output
// stage. Throughput: one cell per cycle when it yields at most one segment
// and the output is not stalled; a cell with two segments holds the output
// stage until both of its segments have been taken.
// Reset: clears all valid bits and sets cell_step to 1.0 (65536).
// Depends on mcs_pkg, mcs_edge and mcs_seg.
module marching_squares_cell import mcs_pkg::*; #(
    parameter int LEVEL_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_in         i_in,
    output logic        o_valid,
    input  logic        i_stall,
    output t_out        o_out
);

    localparam logic [5:0] BAND_MAX = 6'(LEVEL_COUNT - 1);

    typedef struct packed {
        t_pairs             pairs;
        logic [4:0]         band;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
    } t_side;

    typedef struct packed {
        logic       two;
        logic [4:0] band;
    } t_side2;

    logic        adv;
    logic [3:0]  c;
    logic [33:0] sum;
    logic        above;
    logic [4:0]  band_sat;
    logic [30:0] off [4];
    logic [30:0] px  [4];
    logic [30:0] py  [4];
    t_seg_in     seg_in [2];
    t_seg_out    seg_out[2];
    logic        acc;
    logic        sel;
    logic [61:0] step_sq;

    logic [30:0] r_cell_step;
    logic [63:0] r_lim;
    logic        r_v0;
    t_in         r_in0;
    t_side       r_side0;
    logic        r_ev   [EDGE_LAT];
    t_side       r_side [EDGE_LAT];
    logic        r_sv   [SEG_LAT];
    t_side2      r_side2[SEG_LAT];
    logic [1:0]  r_pend;
    t_coords     r_co [2];
    logic [4:0]  r_band;

    assign c[0]  = i_in.corner_ll > i_in.threshold;
    assign c[1]  = i_in.corner_lr > i_in.threshold;
    assign c[2]  = i_in.corner_ur > i_in.threshold;
    assign c[3]  = i_in.corner_ul > i_in.threshold;
    assign sum   = 34'(i_in.corner_ll) + 34'(i_in.corner_lr)
                 + 34'(i_in.corner_ul) + 34'(i_in.corner_ur);
    assign above = sum > {i_in.threshold, 2'b00};
    assign band_sat = ({1'b0, i_in.band_index} > BAND_MAX) ? BAND_MAX[4:0]
                                                          : i_in.band_index;

    assign acc     = o_valid && !i_stall;
    assign adv     = (r_pend == 2'b00) || (acc && r_pend != 2'b11);
    assign o_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_step <= 31'd65536;
        end else if (i_cfg_we) begin
            r_cell_step <= i_cfg_data;
        end
    end

    assign step_sq = 62'(r_cell_step) * 62'(r_cell_step);

    always_ff @(posedge i_clk) begin
        r_lim <= {step_sq, 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int k = 0; k < EDGE_LAT; k++) r_ev[k] <= 1'b0;
            for (int k = 0; k < SEG_LAT; k++) r_sv[k] <= 1'b0;
        end else if (adv) begin
            r_v0 <= i_valid && c != 4'd0 && c != 4'd15;
            r_ev[0] <= r_v0;
            for (int k = 1; k < EDGE_LAT; k++) r_ev[k] <= r_ev[k-1];
            r_sv[0] <= r_ev[EDGE_LAT-1];
            for (int k = 1; k < SEG_LAT; k++) r_sv[k] <= r_sv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_in0         <= i_in;
            r_side0.pairs <= pairs_of(c, above);
            r_side0.band  <= band_sat;
            r_side0.cx    <= i_in.cell_x;
            r_side0.cy    <= i_in.cell_y;
            r_side[0]     <= r_side0;
            for (int k = 1; k < EDGE_LAT; k++) r_side[k] <= r_side[k-1];
            r_side2[0].two  <= r_side[EDGE_LAT-1].pairs.two;
            r_side2[0].band <= r_side[EDGE_LAT-1].band;
            for (int k = 1; k < SEG_LAT; k++) r_side2[k] <= r_side2[k-1];
        end
    end

    mcs_edge u_edge_bot (
        .i_clk, .i_en(adv), .i_va(r_in0.corner_ll), .i_vb(r_in0.corner_lr),
        .i_lvl(r_in0.threshold), .i_step(r_cell_step), .o_off(off[0])
    );
    mcs_edge u_edge_rgt (
        .i_clk, .i_en(adv), .i_va(r_in0.corner_lr), .i_vb(r_in0.corner_ur),
        .i_lvl(r_in0.threshold), .i_step(r_cell_step), .o_off(off[1])
    );
    mcs_edge u_edge_top (
        .i_clk, .i_en(adv), .i_va(r_in0.corner_ul), .i_vb(r_in0.corner_ur),
        .i_lvl(r_in0.threshold), .i_step(r_cell_step), .o_off(off[2])
    );
    mcs_edge u_edge_lft (
        .i_clk, .i_en(adv), .i_va(r_in0.corner_ll), .i_vb(r_in0.corner_ul),
        .i_lvl(r_in0.threshold), .i_step(r_cell_step), .o_off(off[3])
    );

    assign px[0] = off[0];      assign py[0] = '0;
    assign px[1] = r_cell_step; assign py[1] = off[1];
    assign px[2] = off[2];      assign py[2] = r_cell_step;
    assign px[3] = '0;          assign py[3] = off[3];

    always_comb begin
        t_pairs p;
        p = r_side[EDGE_LAT-1].pairs;
        seg_in[0] = '{ax: px[p.a0], ay: py[p.a0], bx: px[p.b0], by: py[p.b0],
                      cx: r_side[EDGE_LAT-1].cx, cy: r_side[EDGE_LAT-1].cy};
        seg_in[1] = '{ax: px[p.a1], ay: py[p.a1], bx: px[p.b1], by: py[p.b1],
                      cx: r_side[EDGE_LAT-1].cx, cy: r_side[EDGE_LAT-1].cy};
    end

    mcs_seg u_seg0 (
        .i_clk, .i_en(adv), .i_seg(seg_in[0]), .i_lim(r_lim), .o_seg(seg_out[0])
    );
    mcs_seg u_seg1 (
        .i_clk, .i_en(adv), .i_seg(seg_in[1]), .i_lim(r_lim), .o_seg(seg_out[1])
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 2'b00;
        end else if (adv) begin
            r_pend[0] <= r_sv[SEG_LAT-1] && seg_out[0].keep;
            r_pend[1] <= r_sv[SEG_LAT-1] && r_side2[SEG_LAT-1].two && seg_out[1].keep;
        end else if (acc) begin
            r_pend[0] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_co[0] <= seg_out[0].co;
            r_co[1] <= seg_out[1].co;
            r_band  <= r_side2[SEG_LAT-1].band;
        end
    end

    assign sel     = !r_pend[0];
    assign o_valid = |r_pend;
    assign o_out.start_x      = r_co[sel].sx;
    assign o_out.start_y      = r_co[sel].sy;
    assign o_out.end_x        = r_co[sel].ex;
    assign o_out.end_y        = r_co[sel].ey;
    assign o_out.segment_band = r_band;
    assign o_out.last_segment = sel || !r_pend[1];

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && o_out.last_segment |-> !o_stall)
        else $error("pipeline held after last segment taken");

    a_two_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_pend == 2'b11 |=> r_pend == 2'b10)
        else $error("second segment lost or repeated");

    a_band_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> {1'b0, o_out.segment_band} <= BAND_MAX)
        else $error("segment band beyond level count");

endmodule

// ===== tb/marching_squares_cell_chk.sv =====
`timescale 1ns / 1ps
// Checker for the marching-squares cell block: watches the request and segment
// channels, predicts segments per accepted cell and compares them. Needs mcs_pkg.
module marching_squares_cell_chk import mcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [30:0] i_cfg_data,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  t_in         i_in,
    input  logic        i_out_valid,
    input  logic        i_stall_out,
    input  t_out        i_out,
    output int          o_errors,
    output int          o_pending
);

    localparam int LEVELS = 32;

    logic [30:0] step_q;
    t_out        seg_q[$];

    assign o_pending = seg_q.size();

    function automatic longint crossing(longint va, longint vb, longint lvl, longint st);
        longint den;
        longint num;
        den = vb - va;
        num = lvl - va;
        if (den == 0) return st >>> 1;
        if ((num <= 0 && den > 0) || (num >= 0 && den < 0)) return 0;
        if (num < 0) num = -num;
        if (den < 0) den = -den;
        if (num >= den) return st;
        return (st * num) / den;
    endfunction

    function automatic logic [31:0] clamp_coord(longint base, longint off);
        longint s;
        s = base + off;
        if (s > 64'sd2147483647) s = 64'sd2147483647;
        if (s < -64'sd2147483648) s = -64'sd2147483648;
        return s[31:0];
    endfunction

    task automatic predict_cell(input t_in c);
        longint vll, vlr, vul, vur, lvl, cx, cy, st, dx, dy;
        longint px[4], py[4];
        int     pr[4];
        int     np, a, b, n;
        logic [3:0] cs;
        logic   above, first;
        logic [4:0] band;
        logic [127:0] sum, lim, d2, q;
        t_out   s;
        t_out   got[$];
        vll = c.corner_ll; vlr = c.corner_lr; vul = c.corner_ul; vur = c.corner_ur;
        lvl = c.threshold; cx = c.cell_x; cy = c.cell_y; st = step_q;
        band = (c.band_index >= LEVELS) ? 5'(LEVELS - 1) : c.band_index;
        cs = {vul > lvl, vur > lvl, vlr > lvl, vll > lvl};
        if (cs == 4'd0 || cs == 4'd15) return;
        px[0] = crossing(vll, vlr, lvl, st); py[0] = 0;
        px[1] = st;                          py[1] = crossing(vlr, vur, lvl, st);
        px[2] = crossing(vul, vur, lvl, st); py[2] = st;
        px[3] = 0;                           py[3] = crossing(vll, vul, lvl, st);
        np = 1;
        case (cs)
            4'd1, 4'd14: begin pr[0] = E_LFT; pr[1] = E_BOT; end
            4'd2, 4'd13: begin pr[0] = E_BOT; pr[1] = E_RGT; end
            4'd3, 4'd12: begin pr[0] = E_LFT; pr[1] = E_RGT; end
            4'd4, 4'd11: begin pr[0] = E_RGT; pr[1] = E_TOP; end
            4'd6, 4'd9: begin pr[0] = E_BOT; pr[1] = E_TOP; end
            4'd7: begin pr[0] = E_LFT; pr[1] = E_TOP; end
            4'd8: begin pr[0] = E_TOP; pr[1] = E_LFT; end
            default: begin
                sum = 128'(vll) + 128'(vlr) + 128'(vul) + 128'(vur);
                lim = 128'(lvl) * 4;
                above = sum > lim;
                first = (cs == 4'd5) ? above : !above;
                np = 2;
                if (first) begin
                    pr[0] = E_BOT; pr[1] = E_RGT; pr[2] = E_TOP; pr[3] = E_LFT;
                end else begin
                    pr[0] = E_LFT; pr[1] = E_BOT; pr[2] = E_RGT; pr[3] = E_TOP;
                end
            end
        endcase
        q = (st != 0) ? (128'(st) * 128'(st) * 4 - 1) / 625 : '0;
        n = 0;
        for (int k = 0; k < np; k++) begin
            a = pr[2 * k]; b = pr[2 * k + 1];
            dx = px[a] - px[b]; dy = py[a] - py[b];
            d2 = 128'(dx * dx) + 128'(dy * dy);
            if (st != 0 && d2 <= q) continue;
            s.start_x = clamp_coord(cx, px[a]);
            s.start_y = clamp_coord(cy, py[a]);
            s.end_x = clamp_coord(cx, px[b]);
            s.end_y = clamp_coord(cy, py[b]);
            s.segment_band = band;
            s.last_segment = 1'b0;
            got = {got, s};
            n++;
        end
        if (n > 0) got[n - 1].last_segment = 1'b1;
        foreach (got[i]) seg_q = {seg_q, got[i]};
    endtask

    task automatic report(input string what, input logic [31:0] seen, input logic [31:0] want);
        $display("MISMATCH %0t: %s got %0h expected %0h", $realtime, what, seen, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_out w;
        if (!i_rst_n) begin
            step_q <= 31'd65536;
        end else begin
            if (i_valid && !i_stall_in) predict_cell(i_in);
            if (i_out_valid && !i_stall_out) begin
                if (seg_q.size() == 0) begin
                    report("unexpected segment", i_out.start_x, '0);
                end else begin
                    w = seg_q.pop_front();
                    if (i_out.start_x !== w.start_x) report("start_x", i_out.start_x, w.start_x);
                    if (i_out.start_y !== w.start_y) report("start_y", i_out.start_y, w.start_y);
                    if (i_out.end_x !== w.end_x) report("end_x", i_out.end_x, w.end_x);
                    if (i_out.end_y !== w.end_y) report("end_y", i_out.end_y, w.end_y);
                    if (i_out.segment_band !== w.segment_band)
                        report("segment_band", i_out.segment_band, w.segment_band);
                    if (i_out.last_segment !== w.last_segment)
                        report("last_segment", i_out.last_segment, w.last_segment);
                end
            end
            if (i_cfg_we) step_q <= i_cfg_data;
        end
    end

endmodule

// ===== tb/marching_squares_cell_tb.sv =====
`timescale 1ns / 1ps
// Top of the marching-squares cell testbench: clock, reset, cell stimulus,
// step settings and verdict. Needs mcs_pkg, the block and its checker.
module marching_squares_cell_tb;
    import mcs_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in         req = '0;
    logic        seg_valid;
    logic        seg_stall = 1'b0;
    t_out        seg;
    int          errors;
    int          pending;
    int          gap_left = 0;
    int          burst_left = 4;

    always #5 clk = ~clk;

    marching_squares_cell dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall), .i_in(req),
        .o_valid(seg_valid), .i_stall(seg_stall), .o_out(seg)
    );

    marching_squares_cell_chk chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall_in(in_stall), .i_in(req),
        .i_out_valid(seg_valid), .i_stall_out(seg_stall), .i_out(seg),
        .o_errors(errors), .o_pending(pending)
    );

    int stall_mode = 0;
    always @(posedge clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: seg_stall <= 1'b0;
            1: seg_stall <= ($urandom_range(0, 3) == 0);
            2: seg_stall <= ($urandom_range(0, 1) == 0);
            default: seg_stall <= ($urandom_range(0, 9) != 0);
        endcase
    end

    function automatic logic [31:0] rnd_value(input logic [31:0] lvl);
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return lvl;
            2: return lvl + $urandom_range(1, 65536);
            3: return lvl - $urandom_range(1, 65536);
            4: return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
            default: return lvl + $urandom_range(0, 4096) - 2048;
        endcase
    endfunction

    function automatic t_in rnd_cell();
        t_in c;
        c.threshold = $urandom;
        c.corner_ll = rnd_value(c.threshold);
        c.corner_lr = rnd_value(c.threshold);
        c.corner_ul = rnd_value(c.threshold);
        c.corner_ur = rnd_value(c.threshold);
        c.band_index = 5'($urandom);
        c.cell_x = ($urandom_range(0, 7) == 0) ? 32'h7FFF_FF00 + $urandom_range(0, 255) : $urandom;
        c.cell_y = ($urandom_range(0, 7) == 0) ? 32'h8000_0000 + $urandom_range(0, 255) : $urandom;
        return c;
    endfunction

    task automatic send(input t_in c);
        while (gap_left > 0) begin
            @(posedge clk);
            in_valid <= 1'b0;
            gap_left--;
        end
        in_valid <= 1'b1;
        req <= c;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap_left > 0) in_valid <= 1'b0;
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_step(input logic [30:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in mk(input logic [31:0] ll, lr, ul, ur, th, input logic [4:0] b,
                               input logic [31:0] x, y);
        t_in c;
        c = '{ll, lr, ul, ur, th, b, x, y};
        return c;
    endfunction

    logic [30:0] steps[6] = '{31'd65536, 31'd1, 31'h7FFF_FFFF, 31'd0, 31'd3276800, 31'd100};

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int c = 0; c < 16; c++)
            send(mk(c[0] ? 32'd200 : 32'd10, c[1] ? 32'd200 : 32'd10,
                    c[3] ? 32'd200 : 32'd10, c[2] ? 32'd200 : 32'd10, 32'd100,
                    5'(c * 2 + 1), 32'(c * 65536), 32'd0));
        send(mk(32'd200, 32'd0, 32'd0, 32'd200, 32'd150, 5'd31, '0, '0));
        send(mk(0, 32'd200, 32'd200, 0, 32'd50, 5'd0, '0, '0));
        send(mk(32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 5'd7, 32'h7FFF_FFFF,
                32'h8000_0000));
        send(mk(32'd101, 32'd100, 32'd100, 32'd100, 32'd100, 5'd5, '0, '0));
        send(mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 32'hFFFF_FFFE, 5'd3, 32'hFFFF_0000, 0));
        drain();
        foreach (steps[s]) begin
            set_step(steps[s]);
            repeat (275) send(rnd_cell());
            drain();
        end
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
